### rtl/slpm_pkg.sv
`default_nettype none

package slpm_pkg;

  // Pattern bytes held in the configuration registers
  localparam int PATTERN_BYTES = 32;

  // Configuration port geometry
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  // Defaults for the top-level parameters
  localparam int              MAX_PATTERN_DEF       = 32;
  localparam longint unsigned MAX_LINE_POSITION_DEF = 65535;

  // Width of the reported start position
  localparam int MATCH_START_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_0_7,
    REG_PATTERN_8_15,
    REG_PATTERN_16_23,
    REG_PATTERN_24_31,
    REG_PATTERN_SIZE,
    REG_FOLD_CASE,
    REG_WHOLE_WORD,
    REG_INVERT_SELECT
  } cfg_reg_t;

  // Live configuration
  typedef struct packed {
    logic [8*PATTERN_BYTES-1:0] pattern;
    logic [5:0]                 pattern_size;
    logic                       fold_case;
    logic                       whole_word;
    logic                       invert_select;
  } slpm_cfg_t;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
    logic       no_byte;
  } slpm_in_t;

  // Result transaction payload
  typedef struct packed {
    logic                     selected;
    logic                     found;
    logic [MATCH_START_W-1:0] match_start;
  } slpm_out_t;

endpackage

`default_nettype wire

### rtl/single_pattern_line_matcher.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    slpm_in_t  (line_byte, line_end, no_byte)
// out_      output     out_valid/out_ready  slpm_out_t (selected, found, match_start)
// cfg_      input      cfg_we               cfg_index selects register, cfg_wdata
//
// One byte per cycle while no stalled result holds a line end. A result is
// loaded from the input register, through the window compare, into the result
// register; this single pass sets the rate.
// Reset is synchronous, active low; config resets to a one-byte zero pattern.
// A stalled result blocks only line-end transactions; other bytes keep flowing.

module single_pattern_line_matcher
  import slpm_pkg::*;
#(
  parameter int              MAX_PATTERN       = MAX_PATTERN_DEF,
  parameter longint unsigned MAX_LINE_POSITION = MAX_LINE_POSITION_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire slpm_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output slpm_out_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  slpm_cfg_t cfg_q;
  slpm_out_t res;

  logic      in_vld_r, in_vld_nxt;
  slpm_in_t  in_item_r, in_item_nxt;
  logic      out_vld_r, out_vld_nxt;
  slpm_out_t out_data_r, out_data_nxt;
  logic      out_free;
  logic      proc;

  slpm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg_q)
  );

  slpm_scan #(
    .MAX_PATTERN       (MAX_PATTERN),
    .MAX_LINE_POSITION (MAX_LINE_POSITION)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_q),
    .take  (proc),
    .item  (in_item_r),
    .res   (res)
  );

  // Advance the held transaction unless its result has nowhere to go
  assign out_free = !out_vld_r || out_ready;
  assign proc     = in_vld_r && (!in_item_r.line_end || out_free);
  assign in_ready = !in_vld_r || proc;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_item_nxt = in_item_r;
    if (in_ready) begin
      in_vld_nxt  = in_valid;
      in_item_nxt = in_data;
    end
  end

  // Load the result register at a line end, drop it once taken
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (proc && in_item_r.line_end) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = res;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A line end that advances always leaves a result behind
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_item_r.line_end |=> out_valid)
    else $error("line end advanced without a result");

  // A byte inside a line never creates a result
  a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !in_item_r.line_end |=> out_valid == $past(out_vld_r && !out_ready))
    else $error("result appeared without a line end");

  // No occurrence means a zero start position
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_start == '0)
    else $error("start position set without an occurrence");

  // Selection follows the invert flag
  a_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.selected == (out_data.found ^ cfg_q.invert_select))
    else $error("selected flag disagrees with found and invert");

endmodule

`default_nettype wire

### rtl/slpm_cfg.sv
`default_nettype none

module slpm_cfg
  import slpm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output slpm_cfg_t                   cfg
);

  slpm_cfg_t cfg_r;
  slpm_cfg_t cfg_nxt;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_0_7:   cfg_nxt.pattern[0*CFG_DATA_W +: CFG_DATA_W] = cfg_wdata;
        REG_PATTERN_8_15:  cfg_nxt.pattern[1*CFG_DATA_W +: CFG_DATA_W] = cfg_wdata;
        REG_PATTERN_16_23: cfg_nxt.pattern[2*CFG_DATA_W +: CFG_DATA_W] = cfg_wdata;
        REG_PATTERN_24_31: cfg_nxt.pattern[3*CFG_DATA_W +: CFG_DATA_W] = cfg_wdata;
        REG_PATTERN_SIZE:  cfg_nxt.pattern_size  = cfg_wdata[5:0];
        REG_FOLD_CASE:     cfg_nxt.fold_case     = cfg_wdata[0];
        REG_WHOLE_WORD:    cfg_nxt.whole_word    = cfg_wdata[0];
        REG_INVERT_SELECT: cfg_nxt.invert_select = cfg_wdata[0];
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern       <= '0;
      cfg_r.pattern_size  <= 6'd1;
      cfg_r.fold_case     <= 1'b0;
      cfg_r.whole_word    <= 1'b0;
      cfg_r.invert_select <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/slpm_scan.sv
`default_nettype none

module slpm_scan
  import slpm_pkg::*;
#(
  parameter int              MAX_PATTERN       = MAX_PATTERN_DEF,
  parameter longint unsigned MAX_LINE_POSITION = MAX_LINE_POSITION_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire slpm_cfg_t cfg,
  input  wire logic      take,
  input  wire slpm_in_t  item,
  output slpm_out_t      res
);

  localparam int DEPTH  = MAX_PATTERN + 1;
  localparam int P_W    = $clog2(MAX_PATTERN + 1);
  localparam int FILL_W = $clog2(MAX_PATTERN + 2);
  localparam int POS_W  = $clog2(MAX_LINE_POSITION + 1);
  localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(MAX_LINE_POSITION);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  function automatic logic is_word(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
           (b >= "A" && b <= "Z") || (b == "_");
  endfunction

  // Line state
  logic [7:0]       win_r [DEPTH];
  logic [7:0]       win_nxt [DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hit_r, hit_nxt;
  logic [POS_W-1:0] hit_start_r, hit_start_nxt;
  logic             pend_r, pend_nxt;
  logic [POS_W-1:0] pend_start_r, pend_start_nxt;

  // Per-byte terms
  logic [7:0]       pat_byte [MAX_PATTERN];
  logic [7:0]       size_ext;
  logic [P_W-1:0]   p;
  logic             has_byte;
  logic [7:0]       c;
  logic [7:0]       shifted [DEPTH];
  logic [FILL_W-1:0] fill_inc;
  logic [POS_W-1:0] pos_inc;
  logic [P_W-1:0]   win_idx;
  logic             pat_ok;
  logic             full;
  logic             left_ok;
  logic [POS_W-1:0] start_cand;
  logic             hit_b, pend_b;
  logic [POS_W-1:0] start_b, pend_start_b;
  logic             hit_f;
  logic [POS_W-1:0] start_f;

  // Spread the pattern into bytes; bytes past the registers read as zero
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < PATTERN_BYTES) begin : g_reg
      assign pat_byte[k] = cfg.pattern[8*k +: 8];
    end else begin : g_zero
      assign pat_byte[k] = '0;
    end
  end

  // Clamp the pattern size into 1..MAX_PATTERN
  always_comb begin
    size_ext = 8'(cfg.pattern_size);
    if (size_ext == 8'd0) begin
      size_ext = 8'd1;
    end else if (size_ext > 8'(MAX_PATTERN)) begin
      size_ext = 8'(MAX_PATTERN);
    end
    p = P_W'(size_ext);
  end

  // Fold the byte and shift it into the window
  assign has_byte = !item.no_byte;
  always_comb begin
    c = item.line_byte;
    if (cfg.fold_case && c >= "A" && c <= "Z") begin
      c = c + 8'd32;
    end
    shifted[0] = c;
    for (int j = 1; j < DEPTH; j++) begin
      shifted[j] = win_r[j-1];
    end
  end

  assign fill_inc = (fill_r < FILL_MAX) ? fill_r + FILL_W'(1) : fill_r;
  assign pos_inc  = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;

  // Compare the newest pattern-size window bytes against the pattern in parallel
  always_comb begin
    pat_ok  = 1'b1;
    win_idx = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < int'(p)) begin
        win_idx = P_W'(int'(p) - 1 - k);
        if (shifted[win_idx] != pat_byte[k]) begin
          pat_ok = 1'b0;
        end
      end
    end
  end

  assign full    = 8'(fill_inc) >= size_ext;
  assign left_ok = (8'(fill_inc) <= size_ext) || !is_word(shifted[p]);

  // Start of an occurrence that ends at this byte
  always_comb begin
    if (pos_r >= POS_MAX) begin
      start_cand = POS_MAX;
    end else if (pos_r >= POS_W'(size_ext - 8'd1)) begin
      start_cand = pos_r - POS_W'(size_ext - 8'd1);
    end else begin
      start_cand = '0;
    end
  end

  // Resolve the pending right edge, then record a new occurrence
  always_comb begin
    hit_b        = hit_r;
    start_b      = hit_start_r;
    pend_b       = pend_r;
    pend_start_b = pend_start_r;
    if (has_byte) begin
      pend_b = 1'b0;
      if (pend_r && !is_word(c) && !hit_r) begin
        hit_b   = 1'b1;
        start_b = pend_start_r;
      end
      if (full && pat_ok && !hit_b) begin
        if (!cfg.whole_word) begin
          hit_b   = 1'b1;
          start_b = start_cand;
        end else if (left_ok) begin
          pend_b       = 1'b1;
          pend_start_b = start_cand;
        end
      end
    end
  end

  // A pending occurrence qualifies at the line edge
  assign hit_f   = hit_b || pend_b;
  assign start_f = hit_b ? start_b : pend_start_b;

  always_comb begin
    res.found       = hit_f;
    res.selected    = hit_f ^ cfg.invert_select;
    res.match_start = hit_f ? MATCH_START_W'(start_f) : '0;
  end

  // Next line state; clear fill, position and occurrence flags at the line end
  always_comb begin
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    pend_nxt       = pend_r;
    hit_start_nxt  = hit_start_r;
    pend_start_nxt = pend_start_r;
    win_nxt        = win_r;
    if (take) begin
      hit_start_nxt  = start_b;
      pend_start_nxt = pend_start_b;
      if (has_byte) begin
        win_nxt = shifted;
      end
      if (item.line_end) begin
        fill_nxt = '0;
        pos_nxt  = '0;
        hit_nxt  = 1'b0;
        pend_nxt = 1'b0;
      end else begin
        if (has_byte) begin
          fill_nxt = fill_inc;
          pos_nxt  = pos_inc;
        end
        hit_nxt  = hit_b;
        pend_nxt = pend_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pos_r  <= '0;
      hit_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
      hit_r  <= hit_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Window bytes and start positions carry no reset
  always_ff @(posedge clk) begin
    win_r        <= win_nxt;
    hit_start_r  <= hit_start_nxt;
    pend_start_r <= pend_start_nxt;
  end

endmodule

`default_nettype wire
